// ----- rtl/mst_pkg.sv -----
`timescale 1ns / 1ps

package mst_pkg;

	typedef struct packed {
		logic        req_type;
		logic [31:0] read_data;
	} req_t;

	typedef struct packed {
		logic        access_valid;
		logic        access_write;
		logic [29:0] word_address;
		logic [31:0] write_data;
		logic        test_done;
		logic        test_passed;
		logic [2:0]  fail_stage;
		logic [21:0] fail_offset;
	} rsp_t;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_SLOT  = 1'b1;

	localparam logic CFG_REGION_BASE = 1'b0;
	localparam logic CFG_REGION_LOG2 = 1'b1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SIMPLE = 3'd1;
	localparam logic [2:0] ST_DATA   = 3'd2;
	localparam logic [2:0] ST_ADDR   = 3'd3;
	localparam logic [2:0] ST_MARCH  = 3'd4;
	localparam logic [2:0] ST_FULL   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	localparam logic [2:0] FAIL_NONE = 3'd0;

	localparam logic [4:0] REGION_LOG2_MIN   = 5'd6;
	localparam logic [4:0] REGION_LOG2_RESET = 5'd22;
	localparam logic [4:0] DATA_LAST_BIT     = 5'd31;

	localparam logic [31:0] SIMPLE_PATTERN = 32'h55AA55AA;
	localparam logic [31:0] ADDR_PATTERN   = 32'hAAAAAAAA;
	localparam logic [31:0] ANTI_PATTERN   = 32'h55555555;
	localparam logic [31:0] MARCH_ZERO     = 32'h00000000;
	localparam logic [31:0] MARCH_ONE      = 32'hFFFFFFFF;

	localparam logic [3:0][31:0] FILL_PATTERNS = {
		32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, 32'h00000000
	};

	localparam int MARCH_SHIFT = 4;
	localparam int STEP_UNROLL = 3;

endpackage

// ----- rtl/mst_engine.sv -----
`timescale 1ns / 1ps

module mst_engine #(
	parameter int MAX_REGION_LOG2 = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  mst_pkg::req_t req,
	input  logic [29:0]   region_base,
	input  logic [4:0]    region_log2,
	output mst_pkg::rsp_t rsp
);
	import mst_pkg::*;

	localparam int OFF_W = MAX_REGION_LOG2;
	localparam int WI_W  = MAX_REGION_LOG2 + 1;
	localparam logic [4:0] MAX_LG = 5'(MAX_REGION_LOG2);

	typedef struct packed {
		logic [2:0]      stage;
		logic [2:0]      pass_step;
		logic [WI_W-1:0] word_index;
		logic [1:0]      pattern_index;
		logic [4:0]      bit_index;
	} seq_t;

	typedef struct packed {
		seq_t             seq;
		logic             halt;
		logic             emit;
		logic             fin;
		logic             wr;
		logic [OFF_W-1:0] off;
		logic [31:0]      pat;
	} step_t;

	function automatic seq_t enter(input logic [2:0] s);
		seq_t n;
		n = '0;
		n.stage = s;
		return n;
	endfunction

	function automatic step_t step_once(input seq_t s, input logic [4:0] lg,
			input logic [WI_W-1:0] size, input logic [WI_W-1:0] march);
		step_t r;
		r = '0;
		r.seq = s;
		case (s.stage)
			ST_SIMPLE: begin
				if (s.pass_step == 3'd0) begin
					r.seq.pass_step = 3'd1;
					r.emit = 1'b1; r.wr = 1'b1; r.pat = SIMPLE_PATTERN;
				end else if (s.pass_step == 3'd1) begin
					r.seq.pass_step = 3'd2;
					r.emit = 1'b1; r.pat = SIMPLE_PATTERN;
				end else begin
					r.seq = enter(ST_DATA);
				end
			end
			ST_DATA: begin
				if (s.pass_step == 3'd0) begin
					r.seq.pass_step = 3'd1;
					r.emit = 1'b1; r.wr = 1'b1; r.pat = 32'd1 << s.bit_index;
				end else if (s.pass_step == 3'd1) begin
					r.seq.pass_step = 3'd2;
					r.emit = 1'b1; r.pat = 32'd1 << s.bit_index;
				end else if (s.bit_index >= DATA_LAST_BIT) begin
					r.seq = enter(ST_ADDR);
				end else begin
					r.seq.bit_index = s.bit_index + 5'd1;
					r.seq.pass_step = 3'd0;
				end
			end
			ST_ADDR: begin
				if (s.pass_step == 3'd0) begin
					if (s.word_index < WI_W'(lg)) begin
						r.seq.word_index = s.word_index + WI_W'(1);
						r.emit = 1'b1; r.wr = 1'b1;
						r.off = OFF_W'(1) << s.word_index; r.pat = ADDR_PATTERN;
					end else begin
						r.seq.pass_step = 3'd1;
					end
				end else if (s.pass_step == 3'd1) begin
					r.seq.pass_step = 3'd2;
					r.seq.word_index = '0;
					r.emit = 1'b1; r.wr = 1'b1; r.pat = ANTI_PATTERN;
				end else if (s.pass_step == 3'd2) begin
					if (s.word_index < WI_W'(lg)) begin
						r.seq.word_index = s.word_index + WI_W'(1);
						r.emit = 1'b1;
						r.off = OFF_W'(1) << s.word_index; r.pat = ADDR_PATTERN;
					end else begin
						r.seq.pass_step = 3'd3;
					end
				end else if (s.pass_step == 3'd3) begin
					r.seq.pass_step = 3'd4;
					r.emit = 1'b1; r.pat = ANTI_PATTERN;
				end else begin
					r.seq = enter(ST_MARCH);
				end
			end
			ST_MARCH: begin
				case (s.pass_step)
					3'd0: begin
						if (s.word_index < march) begin
							r.seq.word_index = s.word_index + WI_W'(1);
							r.emit = 1'b1; r.wr = 1'b1;
							r.off = OFF_W'(s.word_index); r.pat = MARCH_ZERO;
						end else begin
							r.seq.pass_step = 3'd1;
							r.seq.word_index = '0;
						end
					end
					3'd1: begin
						if (s.word_index < march) begin
							r.seq.pass_step = 3'd2;
							r.emit = 1'b1;
							r.off = OFF_W'(s.word_index); r.pat = MARCH_ZERO;
						end else begin
							r.seq.pass_step = 3'd3;
							r.seq.word_index = '0;
						end
					end
					3'd2: begin
						r.seq.pass_step = 3'd1;
						r.seq.word_index = s.word_index + WI_W'(1);
						r.emit = 1'b1; r.wr = 1'b1;
						r.off = OFF_W'(s.word_index); r.pat = MARCH_ONE;
					end
					3'd3: begin
						if (s.word_index < march) begin
							r.seq.pass_step = 3'd4;
							r.emit = 1'b1;
							r.off = OFF_W'(s.word_index); r.pat = MARCH_ONE;
						end else begin
							r.seq.pass_step = 3'd5;
							r.seq.word_index = '0;
						end
					end
					3'd4: begin
						r.seq.pass_step = 3'd3;
						r.seq.word_index = s.word_index + WI_W'(1);
						r.emit = 1'b1; r.wr = 1'b1;
						r.off = OFF_W'(s.word_index); r.pat = MARCH_ZERO;
					end
					3'd5: begin
						if (s.word_index < march) begin
							r.seq.word_index = s.word_index + WI_W'(1);
							r.emit = 1'b1;
							r.off = OFF_W'(march - WI_W'(1) - s.word_index);
							r.pat = MARCH_ZERO;
						end else begin
							r.seq = enter(ST_FULL);
						end
					end
					default: begin
						r.seq = enter(ST_FULL);
					end
				endcase
			end
			ST_FULL: begin
				if (s.pass_step == 3'd0) begin
					if (s.word_index < size) begin
						r.seq.word_index = s.word_index + WI_W'(1);
						r.emit = 1'b1; r.wr = 1'b1;
						r.off = OFF_W'(s.word_index); r.pat = FILL_PATTERNS[s.pattern_index];
					end else begin
						r.seq.pass_step = 3'd1;
						r.seq.word_index = '0;
					end
				end else if (s.pass_step == 3'd1) begin
					if (s.word_index < size) begin
						r.seq.word_index = s.word_index + WI_W'(1);
						r.emit = 1'b1;
						r.off = OFF_W'(s.word_index); r.pat = FILL_PATTERNS[s.pattern_index];
					end else if (s.pattern_index == 2'd3) begin
						r.seq.stage = ST_DONE;
						r.fin = 1'b1;
					end else begin
						r.seq.pattern_index = s.pattern_index + 2'd1;
						r.seq.pass_step = 3'd0;
						r.seq.word_index = '0;
					end
				end else begin
					r.seq.pass_step = 3'd0;
				end
			end
			default: begin
				r.halt = 1'b1;
			end
		endcase
		return r;
	endfunction

	seq_t             seq_q, seq_d;
	logic             pending_q, pending_d;
	logic [31:0]      expected_q, expected_d;
	logic [OFF_W-1:0] pend_off_q, pend_off_d;
	logic             v_done_q, v_done_d;
	logic             v_passed_q, v_passed_d;
	logic [2:0]       v_stage_q, v_stage_d;

	logic [4:0]      lg;
	logic [WI_W-1:0] size;
	logic [WI_W-1:0] march;
	step_t           r;
	logic            have;

	always_comb begin
		if (region_log2 < REGION_LOG2_MIN) begin
			lg = REGION_LOG2_MIN;
		end else if (region_log2 > MAX_LG) begin
			lg = MAX_LG;
		end else begin
			lg = region_log2;
		end
		size  = WI_W'(1) << lg;
		march = size >> MARCH_SHIFT;
	end

	always_comb begin
		seq_d      = seq_q;
		pending_d  = pending_q;
		expected_d = expected_q;
		pend_off_d = pend_off_q;
		v_done_d   = v_done_q;
		v_passed_d = v_passed_q;
		v_stage_d  = v_stage_q;
		r          = '0;
		have       = 1'b0;
		if (req.req_type == REQ_START) begin
			seq_d      = enter(ST_SIMPLE);
			pending_d  = 1'b0;
			expected_d = '0;
			pend_off_d = '0;
			v_done_d   = 1'b0;
			v_passed_d = 1'b0;
			v_stage_d  = FAIL_NONE;
		end else if (seq_q.stage >= ST_SIMPLE && seq_q.stage <= ST_FULL) begin
			if (pending_q) begin
				pending_d = 1'b0;
				if (req.read_data != expected_q) begin
					v_done_d      = 1'b1;
					v_passed_d    = 1'b0;
					v_stage_d     = seq_q.stage;
					seq_d.stage   = ST_DONE;
				end
			end
			if (seq_d.stage != ST_DONE) begin
				r.seq = seq_d;
				// non-issuing steps (pass ends, stage changes) chain at most twice
				for (int i = 0; i < STEP_UNROLL; i++) begin
					if (!r.emit && !r.fin && !r.halt) begin
						r = step_once(r.seq, lg, size, march);
					end
				end
				seq_d = r.seq;
				if (r.fin) begin
					v_done_d   = 1'b1;
					v_passed_d = 1'b1;
					v_stage_d  = FAIL_NONE;
				end
				if (r.emit) begin
					have = 1'b1;
					if (!r.wr) begin
						pending_d  = 1'b1;
						expected_d = r.pat;
						pend_off_d = r.off;
					end
				end
			end
		end
	end

	always_comb begin
		rsp.access_valid = have;
		rsp.access_write = have & r.wr;
		rsp.word_address = have ? region_base + 30'(r.off) : '0;
		rsp.write_data   = (have && r.wr) ? r.pat : '0;
		rsp.test_done    = v_done_d;
		rsp.test_passed  = v_passed_d;
		rsp.fail_stage   = v_stage_d;
		rsp.fail_offset  = (v_done_d && !v_passed_d) ? 22'(pend_off_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= '0;
			pending_q  <= 1'b0;
			expected_q <= '0;
			pend_off_q <= '0;
			v_done_q   <= 1'b0;
			v_passed_q <= 1'b0;
			v_stage_q  <= FAIL_NONE;
		end else if (fire) begin
			seq_q      <= seq_d;
			pending_q  <= pending_d;
			expected_q <= expected_d;
			pend_off_q <= pend_off_d;
			v_done_q   <= v_done_d;
			v_passed_q <= v_passed_d;
			v_stage_q  <= v_stage_d;
		end
	end

	a_pending_active: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (seq_q.stage >= ST_SIMPLE && seq_q.stage <= ST_FULL))
		else $error("read outstanding outside an active stage");

	a_done_matches_stage: assert property (@(posedge clk) disable iff (!arst_n)
		v_done_q == (seq_q.stage == ST_DONE))
		else $error("verdict done flag disagrees with sequencer stage");

	a_fail_stage_set: assert property (@(posedge clk) disable iff (!arst_n)
		(v_stage_q != FAIL_NONE) == (v_done_q && !v_passed_q))
		else $error("fail stage inconsistent with verdict");

endmodule

// ----- rtl/memory_self_test_sequencer.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// req       in   req_valid/req_stall  mst_pkg::req_t (req_type, read_data)
// rsp       out  rsp_valid/rsp_stall  mst_pkg::rsp_t (access and verdict)
// cfg       in   cfg_write_en         cfg_index, cfg_data
//
// One request per clock while req_stall is low; each yields one result, offered once it has
// passed the input register and then the output register.
// The next access comes from a chain of at most three sequencer steps between them.
// Reset clears the sequencer to idle and the region to base 0, log2 22.
// rsp_stall holds the output register; req_stall rises only with both registers full.

module memory_self_test_sequencer #(
	parameter int MAX_REGION_LOG2 = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  mst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mst_pkg::rsp_t rsp,
	input  logic          cfg_write_en,
	input  logic          cfg_index,
	input  logic [29:0]   cfg_data
);
	import mst_pkg::*;

	logic        valid_s1;
	req_t        req_s1;
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	rsp_t        result;
	logic        advance;
	logic        fire;
	logic [29:0] region_base_q;
	logic [4:0]  region_log2_q;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign fire      = valid_s1 && advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
			region_log2_q <= REGION_LOG2_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_REGION_BASE: region_base_q <= cfg_data;
				CFG_REGION_LOG2: region_log2_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_q <= result;
		end
	end

	mst_engine #(
		.MAX_REGION_LOG2(MAX_REGION_LOG2)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.req        (req_s1),
		.region_base(region_base_q),
		.region_log2(region_log2_q),
		.rsp        (result)
	);

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && rsp_valid_q && rsp_stall))
		else $error("request stalled with room in the pipeline");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1.req_type == REQ_START) |=>
		(rsp_valid && !rsp.access_valid && !rsp.test_done))
		else $error("start request produced an access or a stale verdict");

	a_passed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.test_passed) |->
		(rsp.test_done && rsp.fail_stage == FAIL_NONE && !rsp.access_valid))
		else $error("pass verdict with failure info or an access");

endmodule
